FILE: hw/rtl/ihs_pkg.sv
// Shared types and constants for the inflight key hash set.
// Used by ihs_hash, ihs_ctrl, ihs_datapath and the top level.
package ihs_pkg;

    // CAPACITY must be a power of two (8 to 4096)
    localparam int CAPACITY = 64;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int COUNT_W  = SLOT_W + 1;
    localparam int KEY_W    = 63;
    localparam int MIX_W    = 64;
    localparam int HALF_W   = MIX_W / 2;
    localparam int FILL_W   = 7;
    localparam int OP_W     = 2;
    localparam int OUT_W    = 16;

    localparam int MIX_SHIFT = 33;
    localparam logic [MIX_W-1:0] MIX_C1 = 64'hFF51AFD7ED558CCD;
    localparam logic [MIX_W-1:0] MIX_C2 = 64'hC4CEB9FE1A85EC53;

    localparam logic [FILL_W-1:0] MAX_FILL_RST = 7'd48;

    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    typedef struct packed {
        logic load_req;     // capture request, clear result flags
        logic hash_req;     // start hash on incoming key
        logic hash_move;    // start hash on key just read from the table
        logic idx_home;     // idx <= hashed home slot, probe count cleared
        logic idx_step;     // advance idx and probe count
        logic rd_idx;       // read table at idx
        logic wr_req;       // store request key at idx
        logic wr_move;      // store moved key at idx
        logic hole_start;   // free slot idx, start run scan after it
        logic rd_j;         // read and free slot j
        logic j_step;       // advance run scan
        logic cnt_inc;
        logic cnt_dec;
        logic set_present;
        logic set_changed;
        logic set_full;
        logic out_load;
    } ihs_cmd_t;

    typedef struct packed {
        logic            hash_done;
        logic            idx_valid;
        logic            probe_end;
        logic            key_match;
        logic            j_valid;
        logic            j_end;
        logic            present;
        logic            cnt_full;
        logic            out_free;
        logic [OP_W-1:0] op;
    } ihs_sts_t;

endpackage

FILE: hw/rtl/ihs_hash.sv
// Multi-cycle 64-bit mix finalizer giving the home slot of a key.
// One shared 32x32 multiplier, four phases per 64-bit multiply; needs ihs_pkg.
module ihs_hash
    import ihs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [MIX_W-1:0]  key_in,
    output logic              done,
    output logic [SLOT_W-1:0] slot
);

    logic              busy_reg;
    logic              round_reg;
    logic [1:0]        phase_reg;
    logic              done_reg;
    logic [MIX_W-1:0]  v_reg;
    logic [MIX_W-1:0]  acc_reg;
    logic [MIX_W-1:0]  prod_reg;

    logic [MIX_W-1:0]  mul_c;
    logic [HALF_W-1:0] mul_a;
    logic [HALF_W-1:0] mul_b;
    logic [MIX_W-1:0]  mul_res;
    logic [MIX_W-1:0]  sum;

    assign mul_c   = round_reg ? MIX_C2 : MIX_C1;
    assign mul_a   = (phase_reg == 2'd1) ? v_reg[MIX_W-1:HALF_W] : v_reg[HALF_W-1:0];
    assign mul_b   = (phase_reg == 2'd2) ? mul_c[MIX_W-1:HALF_W] : mul_c[HALF_W-1:0];
    assign mul_res = mul_a * mul_b;
    assign sum     = {acc_reg[MIX_W-1:HALF_W] + prod_reg[HALF_W-1:0], acc_reg[HALF_W-1:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            round_reg <= 1'b0;
            phase_reg <= 2'd0;
            done_reg  <= 1'b0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            round_reg <= 1'b0;
            phase_reg <= 2'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && round_reg && (phase_reg == 2'd3);
            if (busy_reg)
            begin
                phase_reg <= phase_reg + 2'd1;
                if (phase_reg == 2'd3)
                begin
                    if (round_reg)
                        busy_reg <= 1'b0;
                    round_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            v_reg <= key_in ^ (key_in >> MIX_SHIFT);
        else if (busy_reg)
        begin
            prod_reg <= mul_res;
            case (phase_reg)
                2'd1:    acc_reg <= prod_reg;
                2'd2:    acc_reg[MIX_W-1:HALF_W] <= acc_reg[MIX_W-1:HALF_W]
                                                  + prod_reg[HALF_W-1:0];
                2'd3:    v_reg <= sum ^ (sum >> MIX_SHIFT);
                default: ;
            endcase
        end
    end

    assign done = done_reg;
    assign slot = v_reg[SLOT_W-1:0];

endmodule

FILE: hw/rtl/ihs_datapath.sv
// Datapath: key memory, slot valid bits, probe and run pointers, count and result register.
// Driven by ihs_ctrl commands; instantiates ihs_hash; needs ihs_pkg.
module ihs_datapath
    import ihs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [KEY_W-1:0]  s_key,
    input  logic [OP_W-1:0]   s_op,
    input  logic              cfg_valid,
    input  logic [FILL_W-1:0] cfg_data,
    input  ihs_cmd_t          cmd,
    output ihs_sts_t          sts,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata
);

    logic [KEY_W-1:0]    key_mem [CAPACITY];
    logic [KEY_W-1:0]    rdata_reg;
    logic [KEY_W-1:0]    req_key_reg;
    logic [KEY_W-1:0]    move_key_reg;
    logic [OP_W-1:0]     op_reg;
    logic [CAPACITY-1:0] valid_reg;
    logic [SLOT_W-1:0]   idx_reg;
    logic [COUNT_W-1:0]  probe_reg;
    logic [SLOT_W-1:0]   j_reg;
    logic [COUNT_W-1:0]  jcnt_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [FILL_W-1:0]   max_fill_reg;
    logic                present_reg;
    logic                changed_reg;
    logic                full_reg;
    logic                out_valid_reg;
    logic [OUT_W-1:0]    out_data_reg;

    logic                hash_start;
    logic [MIX_W-1:0]    hash_key;
    logic                hash_done;
    logic [SLOT_W-1:0]   hash_slot;
    logic                mem_we;
    logic [KEY_W-1:0]    mem_wdata;
    logic                mem_re;
    logic [SLOT_W-1:0]   mem_raddr;

    assign hash_start = cmd.hash_req | cmd.hash_move;
    assign hash_key   = cmd.hash_move ? {1'b0, rdata_reg} : {1'b0, s_key};

    ihs_hash u_hash (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (hash_start),
        .key_in (hash_key),
        .done   (hash_done),
        .slot   (hash_slot)
    );

    assign mem_we    = cmd.wr_req | cmd.wr_move;
    assign mem_wdata = cmd.wr_move ? move_key_reg : req_key_reg;
    assign mem_re    = cmd.rd_idx | cmd.rd_j;
    assign mem_raddr = cmd.rd_j ? j_reg : idx_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            key_mem[idx_reg] <= mem_wdata;
        if (mem_re)
            rdata_reg <= key_mem[mem_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_key_reg <= s_key;
            op_reg      <= s_op;
        end
        if (cmd.hash_move)
            move_key_reg <= rdata_reg;
        if (cmd.out_load)
            out_data_reg <= {{(OUT_W - FILL_W - 3){1'b0}}, FILL_W'(count_reg),
                             full_reg, changed_reg, present_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            idx_reg       <= '0;
            probe_reg     <= '0;
            j_reg         <= '0;
            jcnt_reg      <= '0;
            count_reg     <= '0;
            max_fill_reg  <= MAX_FILL_RST;
            present_reg   <= 1'b0;
            changed_reg   <= 1'b0;
            full_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                max_fill_reg <= cfg_data;

            if (cmd.idx_home)
            begin
                idx_reg   <= hash_slot;
                probe_reg <= '0;
            end
            else if (cmd.idx_step)
            begin
                idx_reg   <= idx_reg + 1'b1;
                probe_reg <= probe_reg + 1'b1;
            end

            if (cmd.hole_start)
            begin
                valid_reg[idx_reg] <= 1'b0;
                j_reg              <= idx_reg + 1'b1;
                jcnt_reg           <= COUNT_W'(1);
            end
            else if (cmd.rd_j)
                valid_reg[j_reg] <= 1'b0;
            else if (mem_we)
                valid_reg[idx_reg] <= 1'b1;

            if (cmd.j_step)
            begin
                j_reg    <= j_reg + 1'b1;
                jcnt_reg <= jcnt_reg + 1'b1;
            end

            if (cmd.cnt_inc)
                count_reg <= count_reg + 1'b1;
            else if (cmd.cnt_dec)
                count_reg <= count_reg - 1'b1;

            if (cmd.load_req)
            begin
                present_reg <= 1'b0;
                changed_reg <= 1'b0;
                full_reg    <= 1'b0;
            end
            else
            begin
                if (cmd.set_present)
                    present_reg <= 1'b1;
                if (cmd.set_changed)
                    changed_reg <= 1'b1;
                if (cmd.set_full)
                    full_reg <= 1'b1;
            end

            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign sts.hash_done = hash_done;
    assign sts.idx_valid = valid_reg[idx_reg];
    assign sts.probe_end = (probe_reg == COUNT_W'(CAPACITY));
    assign sts.key_match = (rdata_reg == req_key_reg);
    assign sts.j_valid   = valid_reg[j_reg];
    assign sts.j_end     = (jcnt_reg == COUNT_W'(CAPACITY));
    assign sts.present   = present_reg;
    assign sts.cnt_full  = ({{(COUNT_W > FILL_W ? COUNT_W - FILL_W : 0){1'b0}}, count_reg}
                            >= {{(FILL_W > COUNT_W ? FILL_W - COUNT_W : 0){1'b0}}, max_fill_reg})
                           || (count_reg >= COUNT_W'(CAPACITY));
    assign sts.out_free  = !out_valid_reg || m_tready;
    assign sts.op        = op_reg;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(CAPACITY))
        else $error("key count above capacity");

    a_insert_free: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> !valid_reg[idx_reg])
        else $error("store into an occupied slot");

    a_probe_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_idx |-> valid_reg[idx_reg])
        else $error("probe read of an empty slot");

    a_out_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || m_tready))
        else $error("result overwritten before it was taken");

    a_dec_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_dec |-> (count_reg != '0))
        else $error("count decremented at zero");
`endif

endmodule

FILE: hw/rtl/ihs_ctrl.sv
// Controller FSM: hash, probe, insert, delete with run re-insertion, result hand-off.
// Issues ihs_cmd_t to ihs_datapath and reads ihs_sts_t back; needs ihs_pkg.
module ihs_ctrl
    import ihs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  ihs_sts_t sts,
    output ihs_cmd_t cmd
);

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b00_0000_0001,
        ST_HASH     = 10'b00_0000_0010,
        ST_PROBE    = 10'b00_0000_0100,
        ST_CMP      = 10'b00_0000_1000,
        ST_ACT      = 10'b00_0001_0000,
        ST_DEL_CHK  = 10'b00_0010_0000,
        ST_DEL_RD   = 10'b00_0100_0000,
        ST_DEL_HASH = 10'b00_1000_0000,
        ST_PLACE    = 10'b01_0000_0000,
        ST_FINISH   = 10'b10_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_req = 1'b1;
                    cmd.hash_req = 1'b1;
                    state_next   = ST_HASH;
                end
            end
            ST_HASH:
            begin
                if (sts.hash_done)
                begin
                    cmd.idx_home = 1'b1;
                    state_next   = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                if (sts.probe_end || !sts.idx_valid)
                    state_next = ST_ACT;
                else
                begin
                    cmd.rd_idx = 1'b1;
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (sts.key_match)
                begin
                    cmd.set_present = 1'b1;
                    state_next      = ST_ACT;
                end
                else
                begin
                    cmd.idx_step = 1'b1;
                    state_next   = ST_PROBE;
                end
            end
            ST_ACT:
            begin
                state_next = ST_FINISH;
                if (sts.op == OP_INSERT && !sts.present)
                begin
                    if (sts.cnt_full)
                        cmd.set_full = 1'b1;
                    else
                    begin
                        cmd.wr_req      = 1'b1;
                        cmd.cnt_inc     = 1'b1;
                        cmd.set_changed = 1'b1;
                    end
                end
                else if (sts.op == OP_DELETE && sts.present)
                begin
                    cmd.hole_start  = 1'b1;
                    cmd.cnt_dec     = 1'b1;
                    cmd.set_changed = 1'b1;
                    state_next      = ST_DEL_CHK;
                end
            end
            ST_DEL_CHK:
            begin
                if (sts.j_end || !sts.j_valid)
                    state_next = ST_FINISH;
                else
                begin
                    cmd.rd_j   = 1'b1;
                    state_next = ST_DEL_RD;
                end
            end
            ST_DEL_RD:
            begin
                cmd.hash_move = 1'b1;
                state_next    = ST_DEL_HASH;
            end
            ST_DEL_HASH:
            begin
                if (sts.hash_done)
                begin
                    cmd.idx_home = 1'b1;
                    state_next   = ST_PLACE;
                end
            end
            ST_PLACE:
            begin
                if (!sts.idx_valid)
                begin
                    cmd.wr_move = 1'b1;
                    cmd.j_step  = 1'b1;
                    state_next  = ST_DEL_CHK;
                end
                else
                    cmd.idx_step = 1'b1;
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

`ifndef SYNTHESIS
    a_move_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.hash_move |-> $past(cmd.rd_j))
        else $error("moved key hashed without a table read");

    a_cmp_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP) |-> $past(cmd.rd_idx))
        else $error("compare without a preceding probe read");

    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_req |=> (state_reg == ST_HASH))
        else $error("accepted item did not start hashing");
`endif

endmodule

FILE: hw/rtl/inflight_key_hash_set.sv
// Top level of the inflight key hash set: stream ports, config port, ctrl and datapath.
// Needs ihs_pkg, ihs_ctrl, ihs_datapath (which holds ihs_hash).
//
// Usage:
//   Slave stream carries one request item: tdata = key, tuser = opcode
//   (lookup, insert, delete). Master stream returns one result item per request.
//   cfg_valid/cfg_data writes max_fill; cfg_ready is always high. Write it
//   only while the block is idle.
// Sequence: hash the key on the shared 32x32 multiplier and hand over the slot;
//   for each occupied slot compared, a memory read and then a compare, until a match,
//   an empty slot or a full lap stops the probe; then act. A delete then walks the run
//   after the freed slot and reads, rehashes and re-places each entry of it,
//   walking occupied slots from its home. Then the result is registered.
// Throughput: one item at a time; the next item is accepted once the current
//   result sits in the output register, so a stalled master holds only the
//   finished result and the following item waits at the end of its own work.
// Reset: the set is empty, count zero, max_fill 48; no clearing pass is needed.
module inflight_key_hash_set
    import ihs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [63:0]       s_tdata,   // [62:0] key, [63] zero
    input  logic [OP_W-1:0]   s_tuser,   // [1:0] opcode
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,   // [0] was_present, [1] changed, [2] full_res,
                                         // [9:3] occupancy, [15:10] zero
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [FILL_W-1:0] cfg_data
);

    ihs_cmd_t cmd;
    ihs_sts_t sts;

    assign cfg_ready = 1'b1;

    ihs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ihs_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_key     (s_tdata[KEY_W-1:0]),
        .s_op      (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

FILE: tb/inflight_key_hash_set_checker.sv
// Checker for the inflight key hash set: watches the request, result and config channels,
// keeps its own copy of the set and compares every result item with the predicted one.
// Depends on ihs_pkg for widths and the mix constants.
module inflight_key_hash_set_checker
    import ihs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [63:0]       s_tdata,   // [62:0] key, [63] zero
    input  logic [OP_W-1:0]   s_tuser,   // [1:0] opcode
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [OUT_W-1:0]  m_tdata,   // [0] was_present, [1] changed, [2] full_res,
                                         // [9:3] occupancy, [15:10] zero
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [FILL_W-1:0] cfg_data,
    output int                errors,
    output int                outstanding_n
);

    typedef struct packed {
        logic [5:0]  pad;
        logic [6:0]  occupancy;
        logic        full_res;
        logic        changed;
        logic        was_present;
    } set_reply_t;

    logic [KEY_W-1:0]  slot_key [CAPACITY];
    bit                slot_used [CAPACITY];
    int                held = 0;
    logic [FILL_W-1:0] fill_limit = MAX_FILL_RST;
    set_reply_t        replies_due [$];
    set_reply_t        want;
    set_reply_t        got;

    function automatic int home_of(input logic [KEY_W-1:0] k);
        logic [MIX_W-1:0] h;
        begin
            h = MIX_W'(k);
            h = h ^ (h >> MIX_SHIFT);
            h = h * MIX_C1;
            h = h ^ (h >> MIX_SHIFT);
            h = h * MIX_C2;
            h = h ^ (h >> MIX_SHIFT);
            return int'(h % MIX_W'(CAPACITY));
        end
    endfunction

    // slot holding k, CAPACITY if absent
    function automatic int find_slot(input logic [KEY_W-1:0] k);
        int i;
        begin
            i = home_of(k);
            for (int p = 0; p < CAPACITY; p++)
            begin
                if (!slot_used[i])
                    return CAPACITY;
                if (slot_key[i] == k)
                    return i;
                i = (i + 1) % CAPACITY;
            end
            return CAPACITY;
        end
    endfunction

    function automatic void place_key(input logic [KEY_W-1:0] k);
        int i;
        begin
            i = home_of(k);
            for (int p = 0; p < CAPACITY; p++)
            begin
                if (!slot_used[i])
                begin
                    slot_used[i] = 1'b1;
                    slot_key[i]  = k;
                    return;
                end
                i = (i + 1) % CAPACITY;
            end
        end
    endfunction

    // free the hole, then re-place every entry of the run behind it
    function automatic void remove_at(input int hole);
        int               j;
        logic [KEY_W-1:0] k;
        begin
            j = (hole + 1) % CAPACITY;
            slot_used[hole] = 1'b0;
            for (int p = 1; p < CAPACITY && slot_used[j]; p++)
            begin
                k = slot_key[j];
                slot_used[j] = 1'b0;
                place_key(k);
                j = (j + 1) % CAPACITY;
            end
        end
    endfunction

    function automatic set_reply_t apply_request(input logic [OP_W-1:0] op,
                                                 input logic [KEY_W-1:0] k);
        set_reply_t r;
        int         at;
        begin
            r  = '0;
            at = find_slot(k);
            r.was_present = (at < CAPACITY);
            if (op == OP_INSERT && !r.was_present)
            begin
                if (held >= int'(fill_limit) || held >= CAPACITY)
                    r.full_res = 1'b1;
                else
                begin
                    place_key(k);
                    held++;
                    r.changed = 1'b1;
                end
            end
            else if (op == OP_DELETE && r.was_present)
            begin
                remove_at(at);
                if (held > 0)
                    held--;
                r.changed = 1'b1;
            end
            r.occupancy = held[6:0];
            return r;
        end
    endfunction

    task automatic compare_field(input string what, input int exp_v, input int got_v);
        if (exp_v != got_v)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, what, exp_v, got_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CAPACITY; i++)
                slot_used[i] = 1'b0;
            held       = 0;
            fill_limit = MAX_FILL_RST;
            replies_due.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = set_reply_t'(m_tdata);
                if (replies_due.size() == 0)
                begin
                    $display("%0t: result %h with none expected", $time, m_tdata);
                    errors++;
                end
                else
                begin
                    want = replies_due.pop_front();
                    compare_field("was_present", want.was_present, got.was_present);
                    compare_field("changed", want.changed, got.changed);
                    compare_field("full_res", want.full_res, got.full_res);
                    compare_field("occupancy", want.occupancy, got.occupancy);
                    compare_field("padding", want.pad, got.pad);
                end
            end
            if (cfg_valid && cfg_ready)
                fill_limit = cfg_data;
            if (s_tvalid && s_tready)
                replies_due.push_back(apply_request(s_tuser, s_tdata[KEY_W-1:0]));
        end
        outstanding_n = replies_due.size();
    end

endmodule

FILE: tb/inflight_key_hash_set_tb.sv
// Testbench top for the inflight key hash set: clock, reset, request and config stimulus,
// random back-pressure, verdict. Needs ihs_pkg, the block and inflight_key_hash_set_checker.
module inflight_key_hash_set_tb;
    import ihs_pkg::*;

    localparam logic [OP_W-1:0]  OP_SPARE    = 2'd3;
    localparam logic [KEY_W-1:0] KEY_TOP     = {KEY_W{1'b1}};
    localparam int               PHASE_N     = 6;
    localparam int               PHASE_ITEMS = 90;
    localparam int               POOL_N      = 72;
    localparam int               CYCLE_LIMIT = 16_000_000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [63:0]       s_tdata = '0;
    logic [OP_W-1:0]   s_tuser = OP_LOOKUP;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [FILL_W-1:0] cfg_data = '0;

    int errors;
    int outstanding_n;
    int cycle_n = 0;

    // insert-heavy phases 0 and 1 fill the table, later ones drain and refill it
    int fill_plan  [PHASE_N] = '{64, 127, 0, 1, 17, 48};
    int insert_pct [PHASE_N] = '{80, 80, 40, 20, 45, 40};
    int delete_pct [PHASE_N] = '{10, 10, 30, 60, 35, 40};

    logic [KEY_W-1:0] key_pool [POOL_N];
    bit               s_burst = 1'b0;
    bit               m_burst = 1'b0;
    logic             m_took = 1'b0;
    int               m_stall = 0;

    inflight_key_hash_set u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    inflight_key_hash_set_checker u_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .errors        (errors),
        .outstanding_n (outstanding_n)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_n++;
        if (cycle_n > CYCLE_LIMIT)
        begin
            $display("inflight_key_hash_set test failed");
            $finish;
        end
    end

    always @(posedge clk)
        m_took <= m_tvalid && m_tready;

    // result side: a fresh stall per item, with stretches of none
    always @(negedge clk)
    begin
        if (m_took)
        begin
            if ($urandom_range(0, 19) == 0)
                m_burst = !m_burst;
            m_stall = m_burst ? 0 : $urandom_range(0, 18);
        end
        if (m_stall > 0)
        begin
            m_tready = 1'b0;
            m_stall--;
        end
        else
            m_tready = 1'b1;
    end

    function automatic logic [KEY_W-1:0] random_key();
        logic [63:0] r;
        begin
            r = {$urandom, $urandom};
            return r[KEY_W-1:0];
        end
    endfunction

    // entered and left at a falling edge; tvalid stays high for a following item
    task automatic push_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k);
        int gap;
        begin
            if ($urandom_range(0, 19) == 0)
                s_burst = !s_burst;
            gap = s_burst ? 0 : $urandom_range(0, 18);
            if (gap > 0)
            begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            s_tvalid = 1'b1;
            s_tdata  = {1'b0, k};
            s_tuser  = op;
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
            @(negedge clk);
        end
    endtask

    task automatic drain(input int settle);
        begin
            s_tvalid = 1'b0;
            while (outstanding_n != 0)
                @(negedge clk);
            repeat (settle) @(negedge clk);
        end
    endtask

    task automatic write_fill(input logic [FILL_W-1:0] v);
        begin
            cfg_data  = v;
            cfg_valid = 1'b1;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            @(negedge clk);
            cfg_valid = 1'b0;
        end
    endtask

    initial
    begin
        int               roll;
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] k;

        key_pool[0] = '0;
        key_pool[1] = KEY_TOP;
        for (int i = 2; i < POOL_N; i++)
            key_pool[i] = random_key();

        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // directed: empty set, key zero, top key, spare opcode, absent deletes
        push_request(OP_LOOKUP, '0);
        push_request(OP_DELETE, '0);
        push_request(OP_INSERT, '0);
        push_request(OP_INSERT, '0);
        push_request(OP_LOOKUP, '0);
        push_request(OP_INSERT, KEY_TOP);
        push_request(OP_SPARE, KEY_TOP);
        push_request(OP_SPARE, 63'd12345);
        push_request(OP_INSERT, KEY_W'({32{2'b01}}));
        push_request(OP_INSERT, KEY_W'({32{2'b10}}));
        push_request(OP_LOOKUP, KEY_TOP);
        push_request(OP_DELETE, '0);
        push_request(OP_LOOKUP, '0);
        push_request(OP_LOOKUP, KEY_W'({32{2'b10}}));
        push_request(OP_DELETE, KEY_TOP);
        push_request(OP_DELETE, KEY_TOP);
        push_request(OP_INSERT, 63'd1);
        push_request(OP_DELETE, KEY_W'({32{2'b01}}));
        push_request(OP_LOOKUP, 63'd1);

        for (int ph = 0; ph < PHASE_N; ph++)
        begin
            drain(4);
            write_fill(FILL_W'(fill_plan[ph]));
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < insert_pct[ph])
                    op = OP_INSERT;
                else if (roll < insert_pct[ph] + delete_pct[ph])
                    op = OP_DELETE;
                else
                    op = ($urandom_range(0, 7) == 0) ? OP_SPARE : OP_LOOKUP;
                if ($urandom_range(0, 9) == 0)
                    k = random_key();
                else
                    k = key_pool[$urandom_range(0, POOL_N - 1)];
                push_request(op, k);
            end
        end

        drain(50);
        if (errors == 0 && outstanding_n == 0)
            $display("inflight_key_hash_set test passed");
        else
            $display("inflight_key_hash_set test failed");
        $finish;
    end

endmodule
